// ===== rtl/core/bop_pkg.sv =====
package bop_pkg;

   localparam int TagDepth      = 256;
   localparam int TagIdxBits    = 8;
   localparam int TagBits       = 12;
   localparam int CandCount     = 52;
   localparam int CandBits      = 6;
   localparam int ScoreBits     = 8;
   localparam int OffsetBits    = 9;
   localparam int Degree        = 3;
   localparam int LineBits      = 58;
   localparam int PageLog2      = 6;
   localparam int RoundBits     = 10;
   localparam int BwBits        = 4;
   localparam int AddrBits      = 3;

   // register addresses (byte address / 4)
   localparam logic [AddrBits-1:0] RegRoundLimit = 3'd0;
   localparam logic [AddrBits-1:0] RegScoreLimit = 3'd1;
   localparam logic [AddrBits-1:0] RegBadScore   = 3'd2;
   localparam logic [AddrBits-1:0] RegBwHigh     = 3'd3;
   localparam logic [AddrBits-1:0] RegBwLow      = 3'd4;

   localparam logic OpAccess = 1'b0;
   localparam logic OpFill   = 1'b1;

   // candidate offset sequence (5-smooth numbers)
   function automatic logic [OffsetBits-1:0] offset_of(input logic [CandBits-1:0] idx);
      logic [OffsetBits-1:0] v;
      unique case (idx)
         6'd0: v = 9'd1;     6'd1: v = 9'd2;     6'd2: v = 9'd3;     6'd3: v = 9'd4;
         6'd4: v = 9'd5;     6'd5: v = 9'd6;     6'd6: v = 9'd8;     6'd7: v = 9'd9;
         6'd8: v = 9'd10;    6'd9: v = 9'd12;    6'd10: v = 9'd15;   6'd11: v = 9'd16;
         6'd12: v = 9'd18;   6'd13: v = 9'd20;   6'd14: v = 9'd24;   6'd15: v = 9'd25;
         6'd16: v = 9'd27;   6'd17: v = 9'd30;   6'd18: v = 9'd32;   6'd19: v = 9'd36;
         6'd20: v = 9'd40;   6'd21: v = 9'd45;   6'd22: v = 9'd48;   6'd23: v = 9'd50;
         6'd24: v = 9'd54;   6'd25: v = 9'd60;   6'd26: v = 9'd64;   6'd27: v = 9'd72;
         6'd28: v = 9'd75;   6'd29: v = 9'd80;   6'd30: v = 9'd81;   6'd31: v = 9'd90;
         6'd32: v = 9'd96;   6'd33: v = 9'd100;  6'd34: v = 9'd108;  6'd35: v = 9'd120;
         6'd36: v = 9'd125;  6'd37: v = 9'd128;  6'd38: v = 9'd135;  6'd39: v = 9'd144;
         6'd40: v = 9'd150;  6'd41: v = 9'd160;  6'd42: v = 9'd162;  6'd43: v = 9'd180;
         6'd44: v = 9'd192;  6'd45: v = 9'd200;  6'd46: v = 9'd216;  6'd47: v = 9'd225;
         6'd48: v = 9'd240;  6'd49: v = 9'd243;  6'd50: v = 9'd250;  6'd51: v = 9'd256;
         6'd52: v = 9'd270;  6'd53: v = 9'd288;  6'd54: v = 9'd300;  6'd55: v = 9'd320;
         6'd56: v = 9'd324;  6'd57: v = 9'd360;  6'd58: v = 9'd375;  6'd59: v = 9'd384;
         6'd60: v = 9'd400;  6'd61: v = 9'd405;  6'd62: v = 9'd432;  default: v = 9'd450;
      endcase
      return v;
   endfunction

   // controller to datapath
   typedef struct packed {
      logic clear_step;  // one step of the reset clearing pass
      logic take;        // capture the input word
      logic lookup;      // registered tag read is valid: learn or record
      logic scan_start;  // begin a top-three scan
      logic scan_step;   // visit one candidate
      logic emit_load;   // build the result list
      logic emit_pop;    // a result word was taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_fill;
      logic end_round;
      logic scan_last;
      logic have_out;
   } stat_type;

endpackage

// ===== rtl/core/bop_ctrl.sv =====
module bop_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  bop_pkg::stat_type stat,
   output bop_pkg::cmd_type  cmd
);
   import bop_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_LOOK  = 7'b0000100,
      ST_DECIDE= 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_BUILD = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.lookup = 1'b1;
            state_in = stat.is_fill ? ST_IDLE : ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.end_round) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_BUILD;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = ST_BUILD;
         end
         ST_BUILD: begin
            cmd.emit_load = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.have_out) state_in = ST_IDLE;
            else if (rsp_ready) cmd.emit_pop = 1'b1;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.have_out) else $error("input taken while results pending");
   a_scan_from_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> state_ff == ST_SCAN) else $error("scan did not start");
endmodule

// ===== rtl/core/bop_datapath.sv =====
module bop_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bop_pkg::cmd_type                     cmd,
   output bop_pkg::stat_type                    stat,
   input  logic                                 req_op,
   input  logic [bop_pkg::LineBits-1:0]         req_line_address,
   input  logic                                 req_was_prefetch,
   input  logic                                 req_cache_hit,
   input  logic [bop_pkg::BwBits-1:0]           req_dram_bandwidth,
   input  logic [bop_pkg::RoundBits-1:0]        round_limit,
   input  logic [bop_pkg::ScoreBits-1:0]        score_limit,
   input  logic [bop_pkg::ScoreBits-1:0]        bad_score_level,
   input  logic [bop_pkg::BwBits-1:0]           bw_high_mark,
   input  logic [bop_pkg::BwBits-1:0]           bw_low_mark,
   output logic                                 rsp_valid,
   output logic [bop_pkg::LineBits-1:0]         rsp_prefetch_address,
   output logic                                 rsp_fill_this_level,
   output logic                                 rsp_last
);
   import bop_pkg::*;

   localparam int KeyBits = ScoreBits + CandBits;

   // recent-requests table, cleared by a sweep after reset
   logic [TagBits-1:0] tag_mem [TagDepth];
   logic [TagBits-1:0] tag_rd_ff;
   logic [TagIdxBits-1:0] clr_ff;

   // score table: registered read; per-entry valid bits make a round clear
   logic [ScoreBits-1:0] score_mem [CandCount];
   logic [ScoreBits-1:0] score_rd_ff;
   logic                 score_rd_ok_ff;
   logic [CandCount-1:0] score_ok_ff;
   logic [CandBits-1:0]  score_ra;
   logic                 score_re;

   logic [OffsetBits-1:0] chosen_ff [Degree];
   logic prefetch_en_ff;
   logic [RoundBits-1:0] round_ff;
   logic [CandBits-1:0] cand_ff;

   logic is_fill_ff, hit_ff, end_round_ff;
   logic [LineBits-1:0] line_ff, key_line_ff;
   logic [BwBits-1:0] bw_ff;

   // scan
   logic [CandBits-1:0] scan_idx_ff;
   logic [KeyBits-1:0] best_ff [Degree];
   logic [Degree-1:0]  best_ok_ff;

   // result list
   logic [LineBits-1:0] out_addr_ff [Degree];
   logic [1:0] out_cnt_ff, out_pos_ff;

   logic [LineBits-1:0] key_line;
   logic [TagIdxBits-1:0] key_idx;
   logic [CandBits-1:0] cand_next;
   logic [ScoreBits-1:0] cur_score, inc_score;
   logic match, fill_ok;
   logic [RoundBits:0] round_next;

   // lookup address: fill trigger or tested access line
   always_comb begin
      if (req_op == OpFill) begin
         key_line = req_was_prefetch ?
                    req_line_address - LineBits'(chosen_ff[0]) : req_line_address;
      end else begin
         key_line = req_line_address - LineBits'(offset_of(cand_ff));
      end
      key_idx = key_line[7:0] ^ key_line[15:8];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) tag_mem[clr_ff] <= '0;
      else if (cmd.lookup && is_fill_ff && fill_ok)
         tag_mem[key_line_ff[7:0] ^ key_line_ff[15:8]] <= key_line_ff[19:8];
      if (cmd.take) tag_rd_ff <= tag_mem[key_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   // score read port: tested candidate on take, next candidate while scanning
   always_comb begin
      score_re = cmd.take || cmd.scan_start || (cmd.scan_step && !stat.scan_last);
      priority if (cmd.take)   score_ra = cand_ff;
      else if (cmd.scan_start) score_ra = '0;
      else                     score_ra = scan_idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup && !is_fill_ff && match) score_mem[cand_ff] <= inc_score;
      if (score_re) score_rd_ff <= score_mem[score_ra];
   end

   assign fill_ok   = (key_line_ff >> PageLog2) == (line_ff >> PageLog2);
   assign match     = tag_rd_ff == key_line_ff[19:8];
   assign cur_score = score_rd_ok_ff ? score_rd_ff : '0;
   assign inc_score = (cur_score == '1) ? cur_score : cur_score + 1'b1;
   assign round_next = {1'b0, round_ff} + 1'b1;
   assign cand_next = (32'(cand_ff) + 1 >= CandCount) ? '0 : cand_ff + 1'b1;

   // capture input word
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         is_fill_ff  <= req_op == OpFill;
         line_ff     <= req_line_address;
         key_line_ff <= key_line;
         hit_ff      <= req_cache_hit;
         bw_ff       <= req_dram_bandwidth;
      end
   end

   // learning state
   always_ff @(posedge clock) begin
      if (reset) begin
         score_ok_ff <= '0;
         score_rd_ok_ff <= 1'b0;
         round_ff <= '0;
         cand_ff <= '0;
         end_round_ff <= 1'b0;
         prefetch_en_ff <= 1'b1;
         chosen_ff[0] <= OffsetBits'(1);
         chosen_ff[1] <= '0;
         chosen_ff[2] <= '0;
         scan_idx_ff <= '0;
         best_ok_ff <= '0;
      end else begin
         if (score_re) score_rd_ok_ff <= score_ok_ff[score_ra];
         if (cmd.lookup && !is_fill_ff) begin
            if (match) score_ok_ff[cand_ff] <= 1'b1;
            end_round_ff <= (match && inc_score >= score_limit) || round_next >= {1'b0, round_limit};
            round_ff <= round_next[RoundBits-1:0];
            cand_ff <= cand_next;
         end
         if (cmd.scan_start) begin
            scan_idx_ff <= '0;
            best_ok_ff <= '0;
         end
         // insertion into a sorted top three; later index wins ties
         if (cmd.scan_step) begin
            logic [KeyBits-1:0] k;
            k = {cur_score, scan_idx_ff};
            if (!best_ok_ff[0] || k > best_ff[0]) begin
               best_ff[2] <= best_ff[1]; best_ff[1] <= best_ff[0]; best_ff[0] <= k;
               best_ok_ff <= {best_ok_ff[1:0], 1'b1};
            end else if (!best_ok_ff[1] || k > best_ff[1]) begin
               best_ff[2] <= best_ff[1]; best_ff[1] <= k;
               best_ok_ff <= {best_ok_ff[1], 2'b11};
            end else if (!best_ok_ff[2] || k > best_ff[2]) begin
               best_ff[2] <= k;
               best_ok_ff <= 3'b111;
            end
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (cmd.emit_load && end_round_ff) begin
            for (int d = 0; d < Degree; d++)
               chosen_ff[d] <= offset_of(best_ff[d][CandBits-1:0]);
            prefetch_en_ff <= best_ff[0][KeyBits-1:CandBits] > bad_score_level;
            score_ok_ff <= '0;
            round_ff <= '0;
            end_round_ff <= 1'b0;
         end
      end
   end

   // result list build: new chosen offsets apply to this access
   logic [OffsetBits-1:0] use_off [Degree];
   logic use_en;
   logic [1:0] degree;
   logic [LineBits-1:0] pf [Degree];
   logic [Degree-1:0] keep;
   always_comb begin
      for (int d = 0; d < Degree; d++)
         use_off[d] = end_round_ff ? offset_of(best_ff[d][CandBits-1:0]) : chosen_ff[d];
      use_en = end_round_ff ? (best_ff[0][KeyBits-1:CandBits] > bad_score_level)
                            : prefetch_en_ff;
      priority if (!use_en)               degree = 2'd0;
      else if (bw_ff > bw_high_mark)      degree = 2'd1;
      else if (bw_ff < bw_low_mark)       degree = 2'd3;
      else                                degree = 2'd2;
      for (int d = 0; d < Degree; d++) begin
         pf[d] = line_ff + LineBits'(use_off[d]);
         keep[d] = (2'(d) < degree) && ((pf[d] >> PageLog2) == (line_ff >> PageLog2));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= '0;
         out_pos_ff <= '0;
      end else if (cmd.emit_load) begin
         logic [1:0] n;
         n = '0;
         for (int d = 0; d < Degree; d++) begin
            if (keep[d]) begin
               out_addr_ff[n] <= pf[d];
               n = n + 1'b1;
            end
         end
         out_cnt_ff <= n;
         out_pos_ff <= '0;
      end else if (cmd.emit_pop) begin
         out_pos_ff <= out_pos_ff + 1'b1;
      end else if (out_pos_ff == out_cnt_ff) begin
         out_cnt_ff <= '0;
         out_pos_ff <= '0;
      end
   end

   assign rsp_valid            = out_pos_ff != out_cnt_ff;
   assign rsp_prefetch_address = out_addr_ff[out_pos_ff];
   assign rsp_fill_this_level  = hit_ff;
   assign rsp_last             = out_pos_ff + 1'b1 == out_cnt_ff;

   assign stat.clear_last = clr_ff == '1;
   assign stat.is_fill    = is_fill_ff;
   assign stat.end_round  = end_round_ff;
   assign stat.scan_last  = 32'(scan_idx_ff) == CandCount - 1;
   assign stat.have_out   = rsp_valid;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      out_pos_ff <= out_cnt_ff) else $error("result position past count");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 2'd3) else $error("too many results");
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> out_pos_ff == out_cnt_ff - 1'b1)
      else $error("last flag misplaced");
endmodule

// ===== rtl/core/best_offset_prefetcher_top.sv =====
// Best-offset prefetcher. Fill words record a trigger tag in a 256-entry
// table; access words learn one candidate offset and return up to three
// same-page prefetch words (none for a fill). After reset a clearing pass
// over all 256 table entries runs before the first word is taken. A fill
// passes through the lookup state; an access through lookup, decide, build
// and emit, with a top-three scan over the score table when a round ends.
module best_offset_prefetcher_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [bop_pkg::LineBits-1:0]  req_line_address,
   input  logic                          req_was_prefetch,
   input  logic                          req_cache_hit,
   input  logic [bop_pkg::BwBits-1:0]    req_dram_bandwidth,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bop_pkg::LineBits-1:0]  rsp_prefetch_address,
   output logic                          rsp_fill_this_level,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bop_pkg::*;

   logic [RoundBits-1:0] round_limit_ff;
   logic [ScoreBits-1:0] score_limit_ff, bad_score_ff;
   logic [BwBits-1:0] bw_high_ff, bw_low_ff;
   logic [AddrBits-1:0] reg_idx;
   cmd_type  cmd;
   stat_type stat;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         round_limit_ff <= 10'd256;
         score_limit_ff <= 8'd31;
         bad_score_ff   <= 8'd1;
         bw_high_ff     <= 4'd11;
         bw_low_ff      <= 4'd4;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            RegRoundLimit: round_limit_ff <= pwdata[RoundBits-1:0];
            RegScoreLimit: score_limit_ff <= pwdata[ScoreBits-1:0];
            RegBadScore:   bad_score_ff   <= pwdata[ScoreBits-1:0];
            RegBwHigh:     bw_high_ff     <= pwdata[BwBits-1:0];
            RegBwLow:      bw_low_ff      <= pwdata[BwBits-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         RegRoundLimit: prdata = 32'(round_limit_ff);
         RegScoreLimit: prdata = 32'(score_limit_ff);
         RegBadScore:   prdata = 32'(bad_score_ff);
         RegBwHigh:     prdata = 32'(bw_high_ff);
         RegBwLow:      prdata = 32'(bw_low_ff);
         default:       prdata = '0;
      endcase
   end

   bop_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_ready, .stat, .cmd
   );

   bop_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .req_op, .req_line_address, .req_was_prefetch, .req_cache_hit, .req_dram_bandwidth,
      .round_limit(round_limit_ff), .score_limit(score_limit_ff),
      .bad_score_level(bad_score_ff), .bw_high_mark(bw_high_ff), .bw_low_mark(bw_low_ff),
      .rsp_valid, .rsp_prefetch_address, .rsp_fill_this_level, .rsp_last
   );
endmodule

// ===== verif/best_offset_prefetcher_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register ports, keeps its own copy of
// the prefetcher state, and compares each response word with the oldest
// predicted prefetch.
module best_offset_prefetcher_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_op,
   input  logic [bop_pkg::LineBits-1:0]  req_line_address,
   input  logic                          req_was_prefetch,
   input  logic                          req_cache_hit,
   input  logic [bop_pkg::BwBits-1:0]    req_dram_bandwidth,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [bop_pkg::LineBits-1:0]  rsp_prefetch_address,
   input  logic                          rsp_fill_this_level,
   input  logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   input  logic                          pready,
   output logic [52*9-1:0]               cand_offsets,
   output int                            pending_words,
   output int                            fail_count
);
   import bop_pkg::*;

   typedef struct packed {
      logic [LineBits-1:0] addr;
      logic                fill;
      logic                last;
   } prefetch_word_type;

   localparam logic [8:0] OFFSETS [0:51] = '{
      9'd1,   9'd2,   9'd3,   9'd4,   9'd5,   9'd6,   9'd8,   9'd9,   9'd10,  9'd12,
      9'd15,  9'd16,  9'd18,  9'd20,  9'd24,  9'd25,  9'd27,  9'd30,  9'd32,  9'd36,
      9'd40,  9'd45,  9'd48,  9'd50,  9'd54,  9'd60,  9'd64,  9'd72,  9'd75,  9'd80,
      9'd81,  9'd90,  9'd96,  9'd100, 9'd108, 9'd120, 9'd125, 9'd128, 9'd135, 9'd144,
      9'd150, 9'd160, 9'd162, 9'd180, 9'd192, 9'd200, 9'd216, 9'd225, 9'd240, 9'd243,
      9'd250, 9'd256};

   // shadow of the block's state and registers
   logic [TagBits-1:0]    tags [TagDepth];
   logic [ScoreBits-1:0]  scores [52];
   logic [OffsetBits-1:0] pick_offs [3];
   logic                  pf_enabled;
   logic [RoundBits-1:0]  round_cnt;
   int                    cand_ptr;
   logic [9:0]            lim_round;
   logic [7:0]            lim_score;
   logic [7:0]            bad_level;
   logic [3:0]            bw_high;
   logic [3:0]            bw_low;

   prefetch_word_type prefetch_q [$];

   always_comb begin
      for (int i = 0; i < 52; i++) cand_offsets[i*9 +: 9] = OFFSETS[i];
   end

   assign pending_words = prefetch_q.size();

   always @(posedge clock) begin
      logic [LineBits-1:0] line, probe, pf;
      logic [7:0]          idx;
      logic                rnd_end;
      int                  cnt_next, degree, pushed, best_key, key;
      int                  picks [3];
      bit                  taken;
      prefetch_word_type   want;

      if (reset) begin
         foreach (tags[i]) tags[i] = '0;
         foreach (scores[i]) scores[i] = '0;
         pick_offs[0] = 9'd1;
         pick_offs[1] = '0;
         pick_offs[2] = '0;
         pf_enabled = 1'b1;
         round_cnt = '0;
         cand_ptr = 0;
         lim_round = 10'd256;
         lim_score = 8'd31;
         bad_level = 8'd1;
         bw_high = 4'd11;
         bw_low = 4'd4;
         prefetch_q.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               RegRoundLimit: lim_round = pwdata[9:0];
               RegScoreLimit: lim_score = pwdata[7:0];
               RegBadScore:   bad_level = pwdata[7:0];
               RegBwHigh:     bw_high = pwdata[3:0];
               RegBwLow:      bw_low = pwdata[3:0];
               default: ;
            endcase
         end

         // response side
         if (rsp_valid && rsp_ready) begin
            if (prefetch_q.size() == 0) begin
               $error("unexpected prefetch word addr %h", rsp_prefetch_address);
               fail_count++;
            end else begin
               want = prefetch_q.pop_front();
               if (rsp_prefetch_address !== want.addr) begin
                  $error("prefetch_address expected %h got %h", want.addr,
                         rsp_prefetch_address);
                  fail_count++;
               end
               if (rsp_fill_this_level !== want.fill) begin
                  $error("fill_this_level expected %0d got %0d", want.fill,
                         rsp_fill_this_level);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end

         // request side
         if (req_valid && req_ready) begin
            line = req_line_address;
            if (req_op == OpFill) begin
               // trigger of a prefetched line is one chosen offset back
               probe = req_was_prefetch ? line - pick_offs[0] : line;
               if (probe[LineBits-1:PageLog2] == line[LineBits-1:PageLog2]) begin
                  idx = probe[7:0] ^ probe[15:8];
                  tags[idx] = probe[19:8];
               end
            end else begin
               // learning step on the current candidate
               rnd_end = 1'b0;
               probe = line - OFFSETS[cand_ptr];
               idx = probe[7:0] ^ probe[15:8];
               if (tags[idx] == probe[19:8]) begin
                  if (scores[cand_ptr] != 8'hFF) scores[cand_ptr]++;
                  if (scores[cand_ptr] >= lim_score) rnd_end = 1'b1;
               end
               cnt_next = round_cnt + 1;
               cand_ptr = (cand_ptr + 1 >= CandCount) ? 0 : cand_ptr + 1;
               if (rnd_end || cnt_next >= lim_round) begin
                  // top three, ties to the higher index
                  for (int k = 0; k < 3; k++) begin
                     best_key = -1;
                     for (int i = 0; i < 52; i++) begin
                        taken = 1'b0;
                        for (int j = 0; j < k; j++) if (picks[j] == i) taken = 1'b1;
                        key = scores[i] * 64 + i;
                        if (!taken && key > best_key) best_key = key;
                     end
                     picks[k] = best_key % 64;
                  end
                  for (int k = 0; k < 3; k++) pick_offs[k] = OFFSETS[picks[k]];
                  pf_enabled = scores[picks[0]] > bad_level;
                  foreach (scores[i]) scores[i] = '0;
                  round_cnt = '0;
               end else begin
                  round_cnt = cnt_next[9:0];
               end

               // issue step
               degree = 0;
               if (pf_enabled) begin
                  if (req_dram_bandwidth > bw_high) degree = 1;
                  else if (req_dram_bandwidth < bw_low) degree = 3;
                  else degree = 2;
               end
               pushed = 0;
               for (int k = 0; k < degree; k++) begin
                  pf = line + pick_offs[k];
                  if (pf[LineBits-1:PageLog2] == line[LineBits-1:PageLog2]) begin
                     want.addr = pf;
                     want.fill = req_cache_hit;
                     want.last = 1'b0;
                     prefetch_q.push_back(want);
                     pushed++;
                  end
               end
               if (pushed > 0) prefetch_q[$].last = 1'b1;
            end
         end
      end
   end

endmodule

// ===== verif/best_offset_prefetcher_top_tb.sv =====
`timescale 1ns / 1ps

module best_offset_prefetcher_top_tb;
   import bop_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainWait  = 80;

   logic                 clock;
   logic                 reset;
   logic                 req_valid, req_ready, req_op, req_was_prefetch, req_cache_hit;
   logic [LineBits-1:0]  req_line_address;
   logic [BwBits-1:0]    req_dram_bandwidth;
   logic                 rsp_valid, rsp_ready, rsp_fill_this_level, rsp_last;
   logic [LineBits-1:0]  rsp_prefetch_address;
   logic                 psel, penable, pwrite, pready;
   logic [4:0]           paddr;
   logic [31:0]          pwdata, prdata;

   logic [52*9-1:0] cand_offsets;
   int              pending_words;
   int              fail_count;
   int              access_cnt;
   int              cycle_cnt = 0;
   bit              steady;

   best_offset_prefetcher_top dut (.*);

   best_offset_prefetcher_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_line_address,
      .req_was_prefetch, .req_cache_hit, .req_dram_bandwidth, .rsp_valid, .rsp_ready,
      .rsp_prefetch_address, .rsp_fill_this_level, .rsp_last, .psel, .penable,
      .pwrite, .paddr, .pwdata, .pready, .cand_offsets, .pending_words, .fail_count);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("best_offset_prefetcher_top_tb NOT OK");
         $finish;
      end
   end

   // response stall
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         @(posedge clock);
      end
   end

   task automatic send(input logic op, input logic [LineBits-1:0] line,
                       input logic was_pf, input logic hit, input logic [3:0] bw);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_line_address <= line;
      req_was_prefetch <= was_pf;
      req_cache_hit <= hit;
      req_dram_bandwidth <= bw;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      if (op == OpAccess) access_cnt++;
   endtask

   task automatic csr_write(input logic [AddrBits-1:0] reg_idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // wait for the block to go idle, then load a full register set
   task automatic reconfigure(input logic [9:0] rl, input logic [7:0] sl,
                              input logic [7:0] bad, input logic [3:0] hi,
                              input logic [3:0] lo);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
      repeat (DrainWait) @(posedge clock);
      csr_write(RegRoundLimit, {22'd0, rl});
      csr_write(RegScoreLimit, {24'd0, sl});
      csr_write(RegBadScore, {24'd0, bad});
      csr_write(RegBwHigh, {28'd0, hi});
      csr_write(RegBwLow, {28'd0, lo});
   endtask

   function automatic logic [LineBits-1:0] rand_line();
      return LineBits'({$urandom, $urandom});
   endfunction

   // mostly fill-then-access pairs aimed at the candidate under test
   task automatic random_phase(input int count);
      logic [LineBits-1:0] trig;
      logic [8:0]          off;
      for (int n = 0; n < count; n += 2) begin
         if ($urandom_range(0, 3) != 0) begin
            trig = rand_line();
            if ($urandom_range(0, 3) == 0) trig[5:0] = 6'(6'h3F - $urandom_range(0, 3));
            off = cand_offsets[(access_cnt % 52) * 9 +: 9];
            send(OpFill, trig, $urandom_range(0, 3) == 0, 1'($urandom), 4'($urandom));
            send(OpAccess, trig + off, 1'($urandom), 1'($urandom), 4'($urandom));
         end else begin
            send(1'($urandom), rand_line(), 1'($urandom), 1'($urandom), 4'($urandom));
            send(OpAccess, rand_line(), 1'($urandom), 1'($urandom), 4'($urandom));
         end
      end
   endtask

   initial begin
      logic [LineBits-1:0] ones;
      ones = '1;
      access_cnt = 0;
      steady = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OpAccess;
      req_line_address <= '0;
      req_was_prefetch <= 1'b0;
      req_cache_hit <= 1'b0;
      req_dram_bandwidth <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, page edges, bandwidth marks, wrap
      send(OpFill, '0, 1'b0, 1'b0, 4'd0);
      send(OpFill, ones, 1'b1, 1'b1, 4'd15);
      send(OpFill, 58'h40, 1'b1, 1'b0, 4'd0);      // trigger in previous page
      send(OpAccess, 58'h1, 1'b1, 1'b0, 4'd0);     // candidate 1 hits line 0
      send(OpAccess, ones, 1'b0, 1'b1, 4'd15);     // wraps out of the page
      send(OpAccess, 58'h3F, 1'b1, 1'b1, 4'd11);   // page end, first offset dropped
      send(OpAccess, 58'h100, 1'b0, 1'b0, 4'd12);
      send(OpAccess, 58'h200, 1'b1, 1'b0, 4'd4);
      send(OpAccess, 58'h300, 1'b0, 1'b1, 4'd3);
      send(OpFill, 58'h1000, 1'b0, 1'b1, 4'd7);
      send(OpAccess, 58'h1005, 1'b1, 1'b0, 4'd7);
      send(OpAccess, ones - 58'h40, 1'b1, 1'b1, 4'd2);
      send(OpFill, 58'h2A_AAAA_AAAA_AAAA, 1'b1, 1'b0, 4'd9);
      send(OpAccess, 58'h15_5555_5555_5555, 1'b0, 1'b1, 4'd6);

      // every round ends at once, with a bad score forcing prefetch off
      reconfigure(10'd1, 8'd1, 8'd255, 4'd15, 4'd0);
      send(OpAccess, 58'h500, 1'b1, 1'b0, 4'd0);
      send(OpFill, 58'h600, 1'b0, 1'b0, 4'd0);
      send(OpAccess, 58'h601, 1'b0, 1'b0, 4'd15);
      random_phase(20);

      // round limit of zero, crossed marks, only a zero best score counts as bad
      reconfigure(10'd0, 8'd255, 8'd0, 4'd0, 4'd15);
      send(OpAccess, 58'h7000, 1'b1, 1'b0, 4'd0);
      send(OpAccess, 58'h7010, 1'b0, 1'b0, 4'd1);
      random_phase(30);

      // short rounds with low score limit, no idling
      steady = 1'b1;
      reconfigure(10'd6, 8'd2, 8'd0, 4'd9, 4'd3);
      random_phase(40);
      steady = 1'b0;

      // longest rounds, crossed marks in the middle
      reconfigure(10'd1023, 8'd255, 8'd1, 4'd7, 4'd8);
      random_phase(30);

      // moderate setting, random gaps again
      reconfigure(10'd60, 8'd3, 8'd1, 4'd11, 4'd4);
      random_phase(50);

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
      repeat (DrainWait) @(posedge clock);
      if (fail_count == 0)
         $display("best_offset_prefetcher_top_tb OK");
      else
         $display("best_offset_prefetcher_top_tb NOT OK");
      $finish;
   end

endmodule
